FILE: hw/rtl/sdp_pkg.sv
// Shared types, constants and tables for the SPS dimension parser.
package sdp_pkg;

   localparam int unsigned MAX_SPS_ID = 32;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam logic [3:0] PREFIX_RESET = 4'd5;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BAD_ID = 2'd1,
      ST_TRUNC  = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      PH_PROFILE, PH_CONSTRAINT, PH_LEVEL, PH_SPS_ID, PH_CHROMA, PH_SEP_PLANE,
      PH_DEPTH_LUMA, PH_DEPTH_CHROMA, PH_BYPASS, PH_MATRIX, PH_LIST_FLAG,
      PH_DELTA, PH_FRAME_NUM, PH_POC_TYPE, PH_POC_LSB, PH_ZERO_FLAG,
      PH_OFF_NONREF, PH_OFF_FIELD, PH_CYCLE, PH_CYCLE_OFF, PH_NUM_REF,
      PH_GAPS, PH_WIDTH, PH_HEIGHT, PH_FRAME_MBS, PH_MBAFF, PH_DIRECT,
      PH_CROP_FLAG, PH_CROP_L, PH_CROP_R, PH_CROP_T, PH_CROP_B, PH_VUI,
      PH_ASPECT_FLAG, PH_ASPECT_IDC, PH_SAR_W, PH_SAR_H, PH_DONE, PH_BAD_ID
   } phase_type;

   typedef enum logic [1:0] {
      RD_FIXED, RD_PREFIX, RD_SUFFIX
   } rd_mode_type;

   // One byte handed from the front end to the bit parser.
   typedef struct packed {
      logic [7:0] data;
      logic       feed;   // byte goes to the bit parser
      logic       last;   // closes the unit
   } entry_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  profile_idc;
      logic [7:0]  level_idc;
      logic [15:0] pic_width;
      logic [15:0] pic_height;
      logic [15:0] aspect_num;
      logic [15:0] aspect_den;
      logic        frames_only;
      logic [3:0]  frame_num_size;
      logic [7:0]  poc_kind;
      logic [3:0]  poc_lsb_size;
   } result_type;

   // Width of each fixed-length field; zero marks an Exp-Golomb code.
   function automatic logic [4:0] field_bits(input phase_type ph);
      logic [4:0] n;
      unique case (ph)
         PH_PROFILE, PH_CONSTRAINT, PH_LEVEL, PH_ASPECT_IDC: n = 5'd8;
         PH_SAR_W, PH_SAR_H: n = 5'd16;
         PH_SEP_PLANE, PH_BYPASS, PH_MATRIX, PH_LIST_FLAG, PH_ZERO_FLAG,
         PH_GAPS, PH_FRAME_MBS, PH_MBAFF, PH_DIRECT, PH_CROP_FLAG, PH_VUI,
         PH_ASPECT_FLAG: n = 5'd1;
         default: n = 5'd0;
      endcase
      return n;
   endfunction

   // Standard sample aspect ratio table, numerator in the upper half.
   function automatic logic [15:0] sar_entry(input logic [4:0] idx);
      logic [15:0] r;
      case (idx)
         5'd1:  r = {8'd1, 8'd1};
         5'd2:  r = {8'd12, 8'd11};
         5'd3:  r = {8'd10, 8'd11};
         5'd4:  r = {8'd16, 8'd11};
         5'd5:  r = {8'd40, 8'd33};
         5'd6:  r = {8'd24, 8'd11};
         5'd7:  r = {8'd20, 8'd11};
         5'd8:  r = {8'd32, 8'd11};
         5'd9:  r = {8'd80, 8'd33};
         5'd10: r = {8'd18, 8'd11};
         5'd11: r = {8'd15, 8'd11};
         5'd12: r = {8'd64, 8'd33};
         5'd13: r = {8'd160, 8'd99};
         5'd14: r = {8'd4, 8'd3};
         5'd15: r = {8'd3, 8'd2};
         5'd16: r = {8'd2, 8'd1};
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/sdp_channels.sv
// Channel interfaces of the SPS dimension parser.
interface sdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source(output valid, data_byte, last_byte, input ready);
   modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface sdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  profile_idc;
   logic [7:0]  level_idc;
   logic [15:0] pic_width;
   logic [15:0] pic_height;
   logic [15:0] aspect_num;
   logic [15:0] aspect_den;
   logic        frames_only;
   logic [3:0]  frame_num_size;
   logic [7:0]  poc_kind;
   logic [3:0]  poc_lsb_size;
   modport source(output valid, status, profile_idc, level_idc, pic_width, pic_height,
                  aspect_num, aspect_den, frames_only, frame_num_size, poc_kind,
                  poc_lsb_size, input ready);
   modport sink(input valid, status, profile_idc, level_idc, pic_width, pic_height,
                aspect_num, aspect_den, frames_only, frame_num_size, poc_kind,
                poc_lsb_size, output ready);
endinterface

interface sdp_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] prefix_skip_bytes;
   modport source(output valid, prefix_skip_bytes, input ready);
   modport sink(input valid, prefix_skip_bytes, output ready);
endinterface

FILE: hw/rtl/sdp_front.sv
// Front end: prefix skipping and emulation-prevention removal.
module sdp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           prefix_skip,
   sdp_req_if.sink              req,
   input  logic                 q_full,
   output logic                 push,
   output sdp_pkg::entry_type   push_entry
);
   logic [3:0] skip_ff, skip_in;
   logic [1:0] zrun_ff, zrun_in;
   logic       held_ff, held_in;
   logic       accept, feed;
   logic [1:0] zr;

   assign req.ready = !q_full;
   assign accept = req.valid && !q_full;

   always_comb begin
      skip_in = skip_ff;
      zrun_in = zrun_ff;
      held_in = held_ff;
      feed = 1'b0;
      zr = held_ff ? 2'd0 : zrun_ff;
      if (skip_ff < prefix_skip) begin
         skip_in = skip_ff + 4'd1;
      end else begin
         held_in = 1'b0;
         zrun_in = zr;
         if (req.data_byte == 8'h03 && zr == 2'd2) begin
            // An escape byte is dropped unless it closes the unit.
            if (!req.last_byte) begin
               held_in = 1'b1;
            end else begin
               feed = 1'b1;
               zrun_in = 2'd0;
            end
         end else begin
            feed = 1'b1;
            if (req.data_byte == 8'h00) zrun_in = (zr == 2'd2) ? 2'd2 : zr + 2'd1;
            else zrun_in = 2'd0;
         end
      end
      if (req.last_byte) begin
         skip_in = 4'd0;
         zrun_in = 2'd0;
         held_in = 1'b0;
      end
   end

   assign push = accept && (feed || req.last_byte);
   assign push_entry = '{data: req.data_byte, feed: feed, last: req.last_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 4'd0;
         zrun_ff <= 2'd0;
         held_ff <= 1'b0;
      end else if (accept) begin
         skip_ff <= skip_in;
         zrun_ff <= zrun_in;
         held_ff <= held_in;
      end
   end
endmodule

FILE: hw/rtl/sdp_queue.sv
// Short first-in first-out queue between front end and bit parser.
module sdp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sdp_pkg::entry_type   push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output sdp_pkg::entry_type   head
);
   localparam int unsigned AW = $clog2(sdp_pkg::QUEUE_DEPTH);

   sdp_pkg::entry_type mem_ff [sdp_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;
   logic          do_push, do_pop;

   assign full = (cnt_ff == (AW+1)'(sdp_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + AW'(1);
         if (do_pop) rd_ff <= rd_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
      end
   end
endmodule

FILE: hw/rtl/sdp_back.sv
// Bit-serial SPS syntax parser with result register.
module sdp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  sdp_pkg::entry_type   q_head,
   output logic                 q_pop,
   output logic                 res_valid,
   input  logic                 res_ready,
   output sdp_pkg::result_type  res
);
   // byte sequencing
   logic       busy_ff, busy_in;
   logic [7:0] sh_ff, sh_in;
   logic [2:0] bcnt_ff, bcnt_in;
   logic       feed_ff, feed_in, last_ff, last_in;
   // parser state
   sdp_pkg::phase_type   ph_ff, ph_in;
   sdp_pkg::rd_mode_type mode_ff, mode_in;
   logic [5:0]  left_ff, left_in, lz_ff, lz_in;
   logic [31:0] code_ff, code_in;
   logic        chr3_ff, chr3_in;
   logic [3:0]  lidx_ff, lidx_in;
   logic [6:0]  lpos_ff, lpos_in;
   logic [7:0]  lsc_ff, lsc_in, nsc_ff, nsc_in;
   logic [8:0]  cyc_ff, cyc_in;
   logic [37:0] wacc_ff, wacc_in, hacc_ff, hacc_in;
   logic        bad_ff, bad_in;
   logic [7:0]  prof_ff, prof_in, lvl_ff, lvl_in, kind_ff, kind_in;
   logic [15:0] anum_ff, anum_in, aden_ff, aden_in;
   logic        fo_ff, fo_in;
   logic [3:0]  fns_ff, fns_in, lsb_ff, lsb_in;
   // result register
   logic                res_valid_ff;
   sdp_pkg::result_type res_ff, res_in;

   logic        out_free, final_step, step_ok, bit_step, emit, fin, go;
   logic        b;
   logic [31:0] c, fv;
   logic [32:0] fv1;
   logic [37:0] dcrop;
   logic [7:0]  ns, sd;
   logic [15:0] sar;
   logic [3:0]  li1;
   logic [6:0]  lp1;
   sdp_pkg::phase_type gph;

   assign out_free = !res_valid_ff || res_ready;
   assign final_step = busy_ff && (!feed_ff || bcnt_ff == 3'd7);
   assign step_ok = !(final_step && last_ff && !out_free);
   assign bit_step = busy_ff && feed_ff && step_ok;
   assign emit = final_step && last_ff && out_free;
   assign q_pop = q_not_empty && (!busy_ff || (final_step && step_ok));
   assign b = sh_ff[7];

   always_comb begin
      busy_in = busy_ff;
      sh_in = sh_ff;
      bcnt_in = bcnt_ff;
      feed_in = feed_ff;
      last_in = last_ff;
      if (bit_step) begin
         sh_in = {sh_ff[6:0], 1'b0};
         bcnt_in = bcnt_ff + 3'd1;
      end
      if (final_step && step_ok) busy_in = 1'b0;
      if (q_pop) begin
         busy_in = 1'b1;
         sh_in = q_head.data;
         bcnt_in = 3'd0;
         feed_in = q_head.feed;
         last_in = q_head.last;
      end
   end

   always_comb begin
      ph_in = ph_ff; mode_in = mode_ff; left_in = left_ff; lz_in = lz_ff;
      code_in = code_ff; chr3_in = chr3_ff; lidx_in = lidx_ff; lpos_in = lpos_ff;
      lsc_in = lsc_ff; nsc_in = nsc_ff; cyc_in = cyc_ff; wacc_in = wacc_ff;
      hacc_in = hacc_ff; bad_in = bad_ff; prof_in = prof_ff; lvl_in = lvl_ff;
      kind_in = kind_ff; anum_in = anum_ff; aden_in = aden_ff; fo_in = fo_ff;
      fns_in = fns_ff; lsb_in = lsb_ff;
      fin = 1'b0; go = 1'b0; gph = ph_ff; fv = 32'd0;
      c = {code_ff[30:0], b};
      fv1 = 33'd0; dcrop = 38'd0; ns = 8'd0; sd = 8'd0; sar = 16'd0;
      li1 = lidx_ff + 4'd1;
      lp1 = lpos_ff + 7'd1;

      if (bit_step && ph_ff != sdp_pkg::PH_DONE && ph_ff != sdp_pkg::PH_BAD_ID) begin
         if (mode_ff == sdp_pkg::RD_PREFIX) begin
            if (!b && lz_ff < 6'd32) begin
               lz_in = lz_ff + 6'd1;
            end else if (lz_ff == 6'd0) begin
               fin = 1'b1;
            end else begin
               mode_in = sdp_pkg::RD_SUFFIX;
               left_in = lz_ff;
               code_in = 32'd0;
            end
         end else begin
            code_in = c;
            left_in = left_ff - 6'd1;
            if (left_ff == 6'd1) begin
               fin = 1'b1;
               if (mode_ff == sdp_pkg::RD_FIXED) fv = c;
               else if (lz_ff >= 6'd32) fv = 32'hFFFF_FFFF;
               else fv = ((32'd1 << lz_ff[4:0]) - 32'd1) + c;
            end
         end
      end

      fv1 = {1'b0, fv} + 33'd1;
      dcrop = {5'd0, fv, 1'b0};
      if (fin) begin
         go = 1'b1;
         unique case (ph_ff)
            sdp_pkg::PH_PROFILE: begin
               prof_in = fv[7:0]; gph = sdp_pkg::PH_CONSTRAINT;
            end
            sdp_pkg::PH_CONSTRAINT: gph = sdp_pkg::PH_LEVEL;
            sdp_pkg::PH_LEVEL: begin
               lvl_in = fv[7:0]; gph = sdp_pkg::PH_SPS_ID;
            end
            sdp_pkg::PH_SPS_ID: begin
               if (fv >= 32'(sdp_pkg::MAX_SPS_ID)) gph = sdp_pkg::PH_BAD_ID;
               else if (prof_ff == 8'd100 || prof_ff == 8'd110 || prof_ff == 8'd122 ||
                        prof_ff == 8'd244 || prof_ff == 8'd44 || prof_ff == 8'd83 ||
                        prof_ff == 8'd86) gph = sdp_pkg::PH_CHROMA;
               else gph = sdp_pkg::PH_FRAME_NUM;
            end
            sdp_pkg::PH_CHROMA: begin
               chr3_in = (fv == 32'd3);
               gph = (fv == 32'd3) ? sdp_pkg::PH_SEP_PLANE : sdp_pkg::PH_DEPTH_LUMA;
            end
            sdp_pkg::PH_SEP_PLANE: gph = sdp_pkg::PH_DEPTH_LUMA;
            sdp_pkg::PH_DEPTH_LUMA: gph = sdp_pkg::PH_DEPTH_CHROMA;
            sdp_pkg::PH_DEPTH_CHROMA: gph = sdp_pkg::PH_BYPASS;
            sdp_pkg::PH_BYPASS: gph = sdp_pkg::PH_MATRIX;
            sdp_pkg::PH_MATRIX: begin
               if (fv[0]) begin
                  lidx_in = 4'd0; gph = sdp_pkg::PH_LIST_FLAG;
               end else gph = sdp_pkg::PH_FRAME_NUM;
            end
            sdp_pkg::PH_LIST_FLAG: begin
               if (fv[0]) begin
                  lpos_in = 7'd0; lsc_in = 8'd8; nsc_in = 8'd8; gph = sdp_pkg::PH_DELTA;
               end else begin
                  lidx_in = li1;
                  gph = (li1 >= (chr3_ff ? 4'd12 : 4'd8)) ? sdp_pkg::PH_FRAME_NUM
                                                          : sdp_pkg::PH_LIST_FLAG;
               end
            end
            sdp_pkg::PH_DELTA: begin
               sd = fv[8:1];
               ns = fv[0] ? lsc_ff + sd + 8'd1 : lsc_ff - sd;
               nsc_in = ns;
               if (ns != 8'd0) lsc_in = ns;
               lpos_in = lp1;
               if (ns == 8'd0 || lp1 >= (lidx_ff < 4'd6 ? 7'd16 : 7'd64)) begin
                  lidx_in = li1;
                  gph = (li1 >= (chr3_ff ? 4'd12 : 4'd8)) ? sdp_pkg::PH_FRAME_NUM
                                                          : sdp_pkg::PH_LIST_FLAG;
               end else gph = sdp_pkg::PH_DELTA;
            end
            sdp_pkg::PH_FRAME_NUM: begin
               fns_in = (fv > 32'd12) ? 4'd12 : fv[3:0]; gph = sdp_pkg::PH_POC_TYPE;
            end
            sdp_pkg::PH_POC_TYPE: begin
               kind_in = (fv > 32'd255) ? 8'd255 : fv[7:0];
               if (fv == 32'd0) gph = sdp_pkg::PH_POC_LSB;
               else if (fv == 32'd1) gph = sdp_pkg::PH_ZERO_FLAG;
               else gph = sdp_pkg::PH_NUM_REF;
            end
            sdp_pkg::PH_POC_LSB: begin
               lsb_in = (fv > 32'd12) ? 4'd12 : fv[3:0]; gph = sdp_pkg::PH_NUM_REF;
            end
            sdp_pkg::PH_ZERO_FLAG: gph = sdp_pkg::PH_OFF_NONREF;
            sdp_pkg::PH_OFF_NONREF: gph = sdp_pkg::PH_OFF_FIELD;
            sdp_pkg::PH_OFF_FIELD: gph = sdp_pkg::PH_CYCLE;
            sdp_pkg::PH_CYCLE: begin
               cyc_in = (fv > 32'd256) ? 9'd256 : fv[8:0];
               gph = (fv == 32'd0) ? sdp_pkg::PH_NUM_REF : sdp_pkg::PH_CYCLE_OFF;
            end
            sdp_pkg::PH_CYCLE_OFF: begin
               cyc_in = cyc_ff - 9'd1;
               gph = (cyc_ff == 9'd1) ? sdp_pkg::PH_NUM_REF : sdp_pkg::PH_CYCLE_OFF;
            end
            sdp_pkg::PH_NUM_REF: gph = sdp_pkg::PH_GAPS;
            sdp_pkg::PH_GAPS: gph = sdp_pkg::PH_WIDTH;
            sdp_pkg::PH_WIDTH: begin
               wacc_in = {1'b0, fv1, 4'd0}; gph = sdp_pkg::PH_HEIGHT;
            end
            sdp_pkg::PH_HEIGHT: begin
               hacc_in = {1'b0, fv1, 4'd0}; gph = sdp_pkg::PH_FRAME_MBS;
            end
            sdp_pkg::PH_FRAME_MBS: begin
               fo_in = fv[0];
               if (fv[0]) gph = sdp_pkg::PH_DIRECT;
               else begin
                  hacc_in = {hacc_ff[36:0], 1'b0}; gph = sdp_pkg::PH_MBAFF;
               end
            end
            sdp_pkg::PH_MBAFF: gph = sdp_pkg::PH_DIRECT;
            sdp_pkg::PH_DIRECT: gph = sdp_pkg::PH_CROP_FLAG;
            sdp_pkg::PH_CROP_FLAG: gph = fv[0] ? sdp_pkg::PH_CROP_L : sdp_pkg::PH_VUI;
            sdp_pkg::PH_CROP_L, sdp_pkg::PH_CROP_R: begin
               if (dcrop > wacc_ff) begin
                  bad_in = 1'b1; wacc_in = 38'd0;
               end else wacc_in = wacc_ff - dcrop;
               gph = (ph_ff == sdp_pkg::PH_CROP_L) ? sdp_pkg::PH_CROP_R : sdp_pkg::PH_CROP_T;
            end
            sdp_pkg::PH_CROP_T, sdp_pkg::PH_CROP_B: begin
               if (dcrop > hacc_ff) begin
                  bad_in = 1'b1; hacc_in = 38'd0;
               end else hacc_in = hacc_ff - dcrop;
               gph = (ph_ff == sdp_pkg::PH_CROP_T) ? sdp_pkg::PH_CROP_B : sdp_pkg::PH_VUI;
            end
            sdp_pkg::PH_VUI: gph = fv[0] ? sdp_pkg::PH_ASPECT_FLAG : sdp_pkg::PH_DONE;
            sdp_pkg::PH_ASPECT_FLAG: gph = fv[0] ? sdp_pkg::PH_ASPECT_IDC : sdp_pkg::PH_DONE;
            sdp_pkg::PH_ASPECT_IDC: begin
               gph = sdp_pkg::PH_DONE;
               if (fv < 32'd17) begin
                  sar = sdp_pkg::sar_entry(fv[4:0]);
                  if (sar[15:8] != 8'd0 && sar[7:0] != 8'd0) begin
                     anum_in = {8'd0, sar[15:8]}; aden_in = {8'd0, sar[7:0]};
                  end else begin
                     anum_in = 16'd1; aden_in = 16'd1;
                  end
               end else if (fv == 32'd255) gph = sdp_pkg::PH_SAR_W;
               else begin
                  anum_in = 16'd1; aden_in = 16'd1;
               end
            end
            sdp_pkg::PH_SAR_W: begin
               anum_in = fv[15:0]; gph = sdp_pkg::PH_SAR_H;
            end
            sdp_pkg::PH_SAR_H: begin
               gph = sdp_pkg::PH_DONE;
               if (anum_ff != 16'd0 && fv[15:0] != 16'd0) aden_in = fv[15:0];
               else begin
                  anum_in = 16'd1; aden_in = 16'd1;
               end
            end
            default: go = 1'b0;
         endcase
      end

      if (go) begin
         ph_in = gph;
         code_in = 32'd0;
         if (gph != sdp_pkg::PH_DONE && gph != sdp_pkg::PH_BAD_ID) begin
            if (sdp_pkg::field_bits(gph) == 5'd0) begin
               mode_in = sdp_pkg::RD_PREFIX; lz_in = 6'd0;
            end else begin
               mode_in = sdp_pkg::RD_FIXED; left_in = {1'b0, sdp_pkg::field_bits(gph)};
            end
         end
      end
   end

   // Result built from the state after the unit's final bit.
   always_comb begin
      res_in = '0;
      if (ph_in == sdp_pkg::PH_BAD_ID) begin
         res_in.status = sdp_pkg::ST_BAD_ID;
         res_in.profile_idc = prof_in;
         res_in.level_idc = lvl_in;
      end else if (ph_in != sdp_pkg::PH_DONE) begin
         res_in.status = sdp_pkg::ST_TRUNC;
      end else begin
         if (bad_in || wacc_in > 38'd65535 || hacc_in > 38'd65535) begin
            res_in.status = sdp_pkg::ST_RANGE;
         end else begin
            res_in.status = sdp_pkg::ST_OK;
            res_in.pic_width = wacc_in[15:0];
            res_in.pic_height = hacc_in[15:0];
         end
         res_in.profile_idc = prof_in;
         res_in.level_idc = lvl_in;
         res_in.aspect_num = anum_in;
         res_in.aspect_den = aden_in;
         res_in.frames_only = fo_in;
         res_in.frame_num_size = fns_in;
         res_in.poc_kind = kind_in;
         res_in.poc_lsb_size = lsb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || emit) begin
         ph_ff <= sdp_pkg::PH_PROFILE; mode_ff <= sdp_pkg::RD_FIXED;
         left_ff <= 6'd8; lz_ff <= 6'd0; code_ff <= 32'd0; chr3_ff <= 1'b0;
         lidx_ff <= 4'd0; lpos_ff <= 7'd0; lsc_ff <= 8'd8; nsc_ff <= 8'd8;
         cyc_ff <= 9'd0; wacc_ff <= 38'd0; hacc_ff <= 38'd0; bad_ff <= 1'b0;
         prof_ff <= 8'd0; lvl_ff <= 8'd0; kind_ff <= 8'd0; anum_ff <= 16'd0;
         aden_ff <= 16'd0; fo_ff <= 1'b0; fns_ff <= 4'd0; lsb_ff <= 4'd0;
      end else begin
         ph_ff <= ph_in; mode_ff <= mode_in; left_ff <= left_in; lz_ff <= lz_in;
         code_ff <= code_in; chr3_ff <= chr3_in; lidx_ff <= lidx_in;
         lpos_ff <= lpos_in; lsc_ff <= lsc_in; nsc_ff <= nsc_in; cyc_ff <= cyc_in;
         wacc_ff <= wacc_in; hacc_ff <= hacc_in; bad_ff <= bad_in;
         prof_ff <= prof_in; lvl_ff <= lvl_in; kind_ff <= kind_in;
         anum_ff <= anum_in; aden_ff <= aden_in; fo_ff <= fo_in;
         fns_ff <= fns_in; lsb_ff <= lsb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (emit) res_valid_ff <= 1'b1;
         else if (res_ready) res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
      bcnt_ff <= bcnt_in;
      feed_ff <= feed_in;
      last_ff <= last_in;
      if (emit) res_ff <= res_in;
   end

   assign res_valid = res_valid_ff;
   assign res = res_ff;
endmodule

FILE: hw/rtl/h264_sps_dimension_parser_core.sv
// Top level of the H.264 SPS dimension parser.
//
// Usage: the req channel carries the raw bytes of one SPS NAL unit, one byte
// per item, with last_byte set on the final byte. The first prefix_skip_bytes
// bytes (written through the csr channel, reset value 5) are dropped, then
// emulation-prevention bytes are removed and the rest is parsed one bit per
// cycle; the final bit of a unit waits while the previous result is held.
// Exactly one rsp item follows each unit, registered when its last byte is
// parsed. A front end takes bytes into a four-entry queue; the back end
// parser drains it byte by byte, popping a byte while parsing the final bit
// of the one before. Dropped bytes enter the queue only if they close the
// unit. When rsp is stalled the held result stays on the port; the parser
// keeps working until it finishes the next unit, and the queue keeps taking
// bytes until it fills, then req.ready drops. Synchronous reset empties the
// queue, drops any pending result and restores the csr register to 5.
// Configuration is taken in any cycle (csr.ready is always high) and must only
// be written while no unit is in flight.
module h264_sps_dimension_parser_core (
   input  logic    clock,
   input  logic    reset,
   sdp_req_if.sink req,
   sdp_rsp_if.source rsp,
   sdp_csr_if.sink csr
);
   logic [3:0]          prefix_ff;
   logic                push, q_full, q_pop, q_not_empty;
   sdp_pkg::entry_type  push_entry, q_head;
   sdp_pkg::result_type res;

   // The prefix length register accepts every write.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) prefix_ff <= sdp_pkg::PREFIX_RESET;
      else if (csr.valid) prefix_ff <= csr.prefix_skip_bytes;
   end

   sdp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .prefix_skip(prefix_ff),
      .req        (req),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   sdp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   sdp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_not_empty(q_not_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .res_valid  (rsp.valid),
      .res_ready  (rsp.ready),
      .res        (res)
   );

   // The result register in the parser drives the response fields directly.
   assign rsp.status         = res.status;
   assign rsp.profile_idc    = res.profile_idc;
   assign rsp.level_idc      = res.level_idc;
   assign rsp.pic_width      = res.pic_width;
   assign rsp.pic_height     = res.pic_height;
   assign rsp.aspect_num     = res.aspect_num;
   assign rsp.aspect_den     = res.aspect_den;
   assign rsp.frames_only    = res.frames_only;
   assign rsp.frame_num_size = res.frame_num_size;
   assign rsp.poc_kind       = res.poc_kind;
   assign rsp.poc_lsb_size   = res.poc_lsb_size;
endmodule

FILE: hw/rtl/sdp_chk.sv
// Port-level checks of the SPS dimension parser, bound to the top level.
module sdp_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_profile_idc,
   input logic [15:0] rsp_pic_width,
   input logic [15:0] rsp_aspect_num,
   input logic [3:0]  rsp_frame_num_size,
   input logic [3:0]  rsp_poc_lsb_size
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_trunc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sdp_pkg::ST_TRUNC |->
         rsp_profile_idc == 8'd0 && rsp_pic_width == 16'd0 && rsp_aspect_num == 16'd0)
      else $error("truncated unit carries values");

   a_badid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sdp_pkg::ST_BAD_ID || rsp_status == sdp_pkg::ST_RANGE) |->
         rsp_pic_width == 16'd0)
      else $error("width given with failing status");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_num_size <= 4'd12 && rsp_poc_lsb_size <= 4'd12)
      else $error("size field not clamped");
endmodule

bind h264_sps_dimension_parser_core sdp_chk u_sdp_chk (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_status        (rsp.status),
   .rsp_profile_idc   (rsp.profile_idc),
   .rsp_pic_width     (rsp.pic_width),
   .rsp_aspect_num    (rsp.aspect_num),
   .rsp_frame_num_size(rsp.frame_num_size),
   .rsp_poc_lsb_size  (rsp.poc_lsb_size)
);

FILE: dv/tb_h264_sps_dimension_parser_core.sv
// Self-checking testbench for the H.264 SPS dimension parser core.
`timescale 1ns / 100ps

// Bit-accurate model of the parser with a queue of the results still to arrive.
class sps_scoreboard;
   logic [3:0]           skip_setting;
   int unsigned          skip_count, zero_run;
   bit                   held_escape;
   sdp_pkg::phase_type   phase;
   sdp_pkg::rd_mode_type mode;
   int unsigned          bits_left, lead_zeros;
   logic [31:0]          code_value, chroma_format;
   int unsigned          list_index, list_position, cycle_left;
   logic [7:0]           last_scale, next_scale;
   logic [63:0]          width_acc, height_acc;
   bit                   size_bad;
   logic [7:0]           profile, level;
   logic [15:0]          sar_num, sar_den;
   bit                   frames_only;
   logic [3:0]           frame_num_size, poc_lsb_size;
   logic [7:0]           poc_kind;
   sdp_pkg::result_type  expected_units[$];
   int                   errors, bytes_taken, units_checked;
   int                   status_seen[4];

   function new();
      skip_setting = sdp_pkg::PREFIX_RESET;
      start_unit();
   endfunction

   function int field_width(sdp_pkg::phase_type p);
      case (p)
         sdp_pkg::PH_PROFILE, sdp_pkg::PH_CONSTRAINT, sdp_pkg::PH_LEVEL,
         sdp_pkg::PH_ASPECT_IDC: return 8;
         sdp_pkg::PH_SAR_W, sdp_pkg::PH_SAR_H: return 16;
         sdp_pkg::PH_SEP_PLANE, sdp_pkg::PH_BYPASS, sdp_pkg::PH_MATRIX,
         sdp_pkg::PH_LIST_FLAG, sdp_pkg::PH_ZERO_FLAG, sdp_pkg::PH_GAPS,
         sdp_pkg::PH_FRAME_MBS, sdp_pkg::PH_MBAFF, sdp_pkg::PH_DIRECT,
         sdp_pkg::PH_CROP_FLAG, sdp_pkg::PH_VUI,
         sdp_pkg::PH_ASPECT_FLAG: return 1;
         default: return 0;
      endcase
   endfunction

   function void enter(sdp_pkg::phase_type p);
      phase = p;
      code_value = 0;
      if (p >= sdp_pkg::PH_DONE) return;
      if (field_width(p) == 0) begin
         mode = sdp_pkg::RD_PREFIX;
         lead_zeros = 0;
      end else begin
         mode = sdp_pkg::RD_FIXED;
         bits_left = field_width(p);
      end
   endfunction

   function void start_unit();
      skip_count = 0; zero_run = 0; held_escape = 0;
      chroma_format = 0; list_index = 0; list_position = 0;
      last_scale = 8; next_scale = 8; cycle_left = 0;
      width_acc = 0; height_acc = 0; size_bad = 0;
      profile = 0; level = 0; sar_num = 0; sar_den = 0; frames_only = 0;
      frame_num_size = 0; poc_kind = 0; poc_lsb_size = 0;
      bits_left = 0; lead_zeros = 0;
      enter(sdp_pkg::PH_PROFILE);
   endfunction

   function void set_aspect(logic [31:0] w, logic [31:0] h);
      if (w != 0 && h != 0) begin
         sar_num = w[15:0]; sar_den = h[15:0];
      end else begin
         sar_num = 1; sar_den = 1;
      end
   endfunction

   // Returns the size left after cropping 2*v, or 0 with the range flag set.
   function logic [63:0] apply_crop(logic [63:0] acc, logic [31:0] v);
      logic [63:0] d;
      d = 64'(v) * 2;
      if (d > acc) begin
         size_bad = 1;
         return 64'd0;
      end
      return acc - d;
   endfunction

   function void next_list();
      list_index++;
      if (list_index >= (chroma_format == 3 ? 12 : 8)) enter(sdp_pkg::PH_FRAME_NUM);
      else enter(sdp_pkg::PH_LIST_FLAG);
   endfunction

   function void field_done(logic [31:0] v);
      logic [31:0] w, h;
      case (phase)
         sdp_pkg::PH_PROFILE: begin profile = v[7:0]; enter(sdp_pkg::PH_CONSTRAINT); end
         sdp_pkg::PH_CONSTRAINT: enter(sdp_pkg::PH_LEVEL);
         sdp_pkg::PH_LEVEL: begin level = v[7:0]; enter(sdp_pkg::PH_SPS_ID); end
         sdp_pkg::PH_SPS_ID: begin
            if (v >= sdp_pkg::MAX_SPS_ID) enter(sdp_pkg::PH_BAD_ID);
            else if (profile inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83,
                                     8'd86}) enter(sdp_pkg::PH_CHROMA);
            else enter(sdp_pkg::PH_FRAME_NUM);
         end
         sdp_pkg::PH_CHROMA: begin
            chroma_format = v;
            enter(v == 3 ? sdp_pkg::PH_SEP_PLANE : sdp_pkg::PH_DEPTH_LUMA);
         end
         sdp_pkg::PH_SEP_PLANE: enter(sdp_pkg::PH_DEPTH_LUMA);
         sdp_pkg::PH_DEPTH_LUMA: enter(sdp_pkg::PH_DEPTH_CHROMA);
         sdp_pkg::PH_DEPTH_CHROMA: enter(sdp_pkg::PH_BYPASS);
         sdp_pkg::PH_BYPASS: enter(sdp_pkg::PH_MATRIX);
         sdp_pkg::PH_MATRIX: begin
            if (v != 0) begin list_index = 0; enter(sdp_pkg::PH_LIST_FLAG); end
            else enter(sdp_pkg::PH_FRAME_NUM);
         end
         sdp_pkg::PH_LIST_FLAG: begin
            if (v != 0) begin
               list_position = 0; last_scale = 8; next_scale = 8;
               enter(sdp_pkg::PH_DELTA);
            end else next_list();
         end
         sdp_pkg::PH_DELTA: begin
            if (v[0]) next_scale = last_scale + 8'(v >> 1) + 8'd1;
            else next_scale = last_scale - 8'(v >> 1);
            if (next_scale != 0) last_scale = next_scale;
            list_position++;
            if (next_scale == 0 || list_position >= (list_index < 6 ? 16 : 64))
               next_list();
            else enter(sdp_pkg::PH_DELTA);
         end
         sdp_pkg::PH_FRAME_NUM: begin
            frame_num_size = v > 12 ? 4'd12 : v[3:0];
            enter(sdp_pkg::PH_POC_TYPE);
         end
         sdp_pkg::PH_POC_TYPE: begin
            poc_kind = v > 255 ? 8'd255 : v[7:0];
            if (v == 0) enter(sdp_pkg::PH_POC_LSB);
            else if (v == 1) enter(sdp_pkg::PH_ZERO_FLAG);
            else enter(sdp_pkg::PH_NUM_REF);
         end
         sdp_pkg::PH_POC_LSB: begin
            poc_lsb_size = v > 12 ? 4'd12 : v[3:0];
            enter(sdp_pkg::PH_NUM_REF);
         end
         sdp_pkg::PH_ZERO_FLAG: enter(sdp_pkg::PH_OFF_NONREF);
         sdp_pkg::PH_OFF_NONREF: enter(sdp_pkg::PH_OFF_FIELD);
         sdp_pkg::PH_OFF_FIELD: enter(sdp_pkg::PH_CYCLE);
         sdp_pkg::PH_CYCLE: begin
            cycle_left = v > 256 ? 256 : v;
            enter(cycle_left == 0 ? sdp_pkg::PH_NUM_REF : sdp_pkg::PH_CYCLE_OFF);
         end
         sdp_pkg::PH_CYCLE_OFF: begin
            cycle_left--;
            enter(cycle_left == 0 ? sdp_pkg::PH_NUM_REF : sdp_pkg::PH_CYCLE_OFF);
         end
         sdp_pkg::PH_NUM_REF: enter(sdp_pkg::PH_GAPS);
         sdp_pkg::PH_GAPS: enter(sdp_pkg::PH_WIDTH);
         sdp_pkg::PH_WIDTH: begin
            width_acc = 16 * (64'(v) + 1); enter(sdp_pkg::PH_HEIGHT);
         end
         sdp_pkg::PH_HEIGHT: begin
            height_acc = 16 * (64'(v) + 1); enter(sdp_pkg::PH_FRAME_MBS);
         end
         sdp_pkg::PH_FRAME_MBS: begin
            frames_only = v[0];
            if (v != 0) enter(sdp_pkg::PH_DIRECT);
            else begin height_acc = height_acc * 2; enter(sdp_pkg::PH_MBAFF); end
         end
         sdp_pkg::PH_MBAFF: enter(sdp_pkg::PH_DIRECT);
         sdp_pkg::PH_DIRECT: enter(sdp_pkg::PH_CROP_FLAG);
         sdp_pkg::PH_CROP_FLAG: enter(v != 0 ? sdp_pkg::PH_CROP_L : sdp_pkg::PH_VUI);
         sdp_pkg::PH_CROP_L: begin
            width_acc = apply_crop(width_acc, v); enter(sdp_pkg::PH_CROP_R);
         end
         sdp_pkg::PH_CROP_R: begin
            width_acc = apply_crop(width_acc, v); enter(sdp_pkg::PH_CROP_T);
         end
         sdp_pkg::PH_CROP_T: begin
            height_acc = apply_crop(height_acc, v); enter(sdp_pkg::PH_CROP_B);
         end
         sdp_pkg::PH_CROP_B: begin
            height_acc = apply_crop(height_acc, v); enter(sdp_pkg::PH_VUI);
         end
         sdp_pkg::PH_VUI: enter(v != 0 ? sdp_pkg::PH_ASPECT_FLAG : sdp_pkg::PH_DONE);
         sdp_pkg::PH_ASPECT_FLAG:
            enter(v != 0 ? sdp_pkg::PH_ASPECT_IDC : sdp_pkg::PH_DONE);
         sdp_pkg::PH_ASPECT_IDC: begin
            if (v < 17) begin
               case (v)
                  1: begin w = 1; h = 1; end
                  2: begin w = 12; h = 11; end
                  3: begin w = 10; h = 11; end
                  4: begin w = 16; h = 11; end
                  5: begin w = 40; h = 33; end
                  6: begin w = 24; h = 11; end
                  7: begin w = 20; h = 11; end
                  8: begin w = 32; h = 11; end
                  9: begin w = 80; h = 33; end
                  10: begin w = 18; h = 11; end
                  11: begin w = 15; h = 11; end
                  12: begin w = 64; h = 33; end
                  13: begin w = 160; h = 99; end
                  14: begin w = 4; h = 3; end
                  15: begin w = 3; h = 2; end
                  16: begin w = 2; h = 1; end
                  default: begin w = 0; h = 0; end
               endcase
               set_aspect(w, h);
               enter(sdp_pkg::PH_DONE);
            end else if (v == 255) enter(sdp_pkg::PH_SAR_W);
            else begin set_aspect(0, 0); enter(sdp_pkg::PH_DONE); end
         end
         sdp_pkg::PH_SAR_W: begin sar_num = v[15:0]; enter(sdp_pkg::PH_SAR_H); end
         sdp_pkg::PH_SAR_H: begin set_aspect(32'(sar_num), v); enter(sdp_pkg::PH_DONE); end
         default: ;
      endcase
   endfunction

   function void take_bit(bit b);
      if (phase >= sdp_pkg::PH_DONE) return;
      if (mode == sdp_pkg::RD_PREFIX) begin
         if (b == 0 && lead_zeros < 32) begin lead_zeros++; return; end
         if (lead_zeros == 0) begin field_done(0); return; end
         mode = sdp_pkg::RD_SUFFIX;
         bits_left = lead_zeros;
         code_value = 0;
         return;
      end
      code_value = {code_value[30:0], b};
      bits_left--;
      if (bits_left != 0) return;
      if (mode == sdp_pkg::RD_FIXED) field_done(code_value);
      else if (lead_zeros >= 32) field_done(32'hFFFF_FFFF);
      else field_done(((32'd1 << lead_zeros) - 1) + code_value);
   endfunction

   function void take_payload(logic [7:0] b, bit last);
      if (held_escape) begin held_escape = 0; zero_run = 0; end
      if (b == 8'h03 && zero_run >= 2) begin
         if (!last) begin held_escape = 1; return; end
         for (int i = 7; i >= 0; i--) take_bit(b[i]);
         zero_run = 0;
         return;
      end
      for (int i = 7; i >= 0; i--) take_bit(b[i]);
      zero_run = (b == 0) ? (zero_run < 2 ? zero_run + 1 : 2) : 0;
   endfunction

   // Called for every accepted input item.
   function void note_byte(logic [7:0] b, bit last);
      sdp_pkg::result_type r;
      bytes_taken++;
      if (skip_count < skip_setting) skip_count++;
      else take_payload(b, last);
      if (!last) return;
      r = '0;
      if (phase == sdp_pkg::PH_BAD_ID) begin
         r.status = sdp_pkg::ST_BAD_ID; r.profile_idc = profile; r.level_idc = level;
      end else if (phase != sdp_pkg::PH_DONE) begin
         r.status = sdp_pkg::ST_TRUNC;
      end else begin
         r.status = (size_bad || width_acc > 65535 || height_acc > 65535) ?
                    sdp_pkg::ST_RANGE : sdp_pkg::ST_OK;
         r.profile_idc = profile;
         r.level_idc = level;
         if (r.status == sdp_pkg::ST_OK) begin
            r.pic_width = width_acc[15:0]; r.pic_height = height_acc[15:0];
         end
         r.aspect_num = sar_num;
         r.aspect_den = sar_den;
         r.frames_only = frames_only;
         r.frame_num_size = frame_num_size;
         r.poc_kind = poc_kind;
         r.poc_lsb_size = poc_lsb_size;
      end
      expected_units.push_back(r);
      start_unit();
   endfunction

   function void compare(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
      end
   endfunction

   // Called for every accepted result item.
   function void check_result(sdp_pkg::result_type got);
      sdp_pkg::result_type e;
      if (expected_units.size() == 0) begin
         errors++;
         $display("%0t: unexpected result, expected none actual status %0d",
                  $time, got.status);
         return;
      end
      e = expected_units.pop_front();
      units_checked++;
      status_seen[e.status]++;
      compare("status", 16'(e.status), 16'(got.status));
      compare("profile_idc", 16'(e.profile_idc), 16'(got.profile_idc));
      compare("level_idc", 16'(e.level_idc), 16'(got.level_idc));
      compare("pic_width", e.pic_width, got.pic_width);
      compare("pic_height", e.pic_height, got.pic_height);
      compare("aspect_num", e.aspect_num, got.aspect_num);
      compare("aspect_den", e.aspect_den, got.aspect_den);
      compare("frames_only", 16'(e.frames_only), 16'(got.frames_only));
      compare("frame_num_size", 16'(e.frame_num_size), 16'(got.frame_num_size));
      compare("poc_kind", 16'(e.poc_kind), 16'(got.poc_kind));
      compare("poc_lsb_size", 16'(e.poc_lsb_size), 16'(got.poc_lsb_size));
   endfunction
endclass

module tb_h264_sps_dimension_parser_core;

   localparam int CYCLE_LIMIT = 600000;

   // Kinds of generated units.
   localparam int UNIT_RANDOM   = 0;
   localparam int UNIT_BAD_ID   = 1;
   localparam int UNIT_LONG     = 2;
   localparam int UNIT_EXTREME  = 3;
   localparam int UNIT_NOISE    = 4;

   logic clock;
   logic reset;

   sdp_req_if req_ch();
   sdp_rsp_if rsp_ch();
   sdp_csr_if csr_ch();

   h264_sps_dimension_parser_core dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch)
   );

   sps_scoreboard sps_model = new();

   // Idle bursts are allowed on both sides until the closing phase turns them off.
   bit idling_on;
   int rsp_stall_left;
   longint cycles;

   // Bit string and byte list of the unit that is being built.
   bit bitstream[$];
   logic [7:0] nal_bytes[$];

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // The design is sampled at the rising edge; every accepted item goes to the model.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sps_model.note_byte(req_ch.data_byte, req_ch.last_byte);
         if (rsp_ch.valid && rsp_ch.ready)
            sps_model.check_result('{sdp_pkg::status_type'(rsp_ch.status),
                                     rsp_ch.profile_idc,
                                     rsp_ch.level_idc, rsp_ch.pic_width,
                                     rsp_ch.pic_height, rsp_ch.aspect_num,
                                     rsp_ch.aspect_den, rsp_ch.frames_only,
                                     rsp_ch.frame_num_size, rsp_ch.poc_kind,
                                     rsp_ch.poc_lsb_size});
         if (csr_ch.valid && csr_ch.ready)
            sps_model.skip_setting = csr_ch.prefix_skip_bytes;
      end
   end

   // Handshake flags, captured at the rising edge and read by the drivers at the falling one.
   bit req_taken, csr_taken;
   always @(posedge clock) begin
      req_taken <= req_ch.valid && req_ch.ready;
      csr_taken <= csr_ch.valid && csr_ch.ready;
   end

   // The result side stalls in random bursts of random length while idling is on.
   always @(negedge clock) begin
      if (idling_on && rsp_stall_left == 0 && $urandom_range(0, 5) == 0)
         rsp_stall_left = $urandom_range(1, 10);
      rsp_ch.ready = (rsp_stall_left == 0);
      if (rsp_stall_left > 0) rsp_stall_left--;
   end

   // Watchdog: a hung design fails the run instead of hanging the simulator.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("[h264_sps_dimension_parser_core] ERROR");
         $finish;
      end
   end

   task automatic put_bits(longint unsigned v, int n);
      for (int i = n - 1; i >= 0; i--) bitstream.push_back(v[i]);
   endtask

   // Exp-Golomb code of v, up to the all-ones value with its 32 leading zeros.
   task automatic put_ue(longint unsigned v);
      longint unsigned x;
      int n;
      x = v + 1;
      n = 0;
      while ((x >> (n + 1)) != 0) n++;
      put_bits(0, n);
      put_bits(x, n + 1);
   endtask

   function automatic longint unsigned pick_ue(int top);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 64'hFFFF_FFFF;
      if (r < 8) return $urandom;
      return $urandom_range(0, top);
   endfunction

   // Scaling lists: the generator follows the same stop rule as the parser.
   task automatic put_scaling_lists(int count);
      logic [7:0] last_s, next_s;
      longint unsigned d;
      int pos, size;
      for (int li = 0; li < count; li++) begin
         bit present;
         present = $urandom_range(0, 2) == 0;
         put_bits(present, 1);
         if (present) begin
            last_s = 8;
            pos = 0;
            size = li < 6 ? 16 : 64;
            do begin
               d = ($urandom_range(0, 3) == 0) ? pick_ue(600) : 0;
               put_ue(d);
               if (d[0]) next_s = last_s + 8'(d >> 1) + 8'd1;
               else next_s = last_s - 8'(d >> 1);
               if (next_s != 0) last_s = next_s;
               pos++;
            end while (next_s != 0 && pos < size);
         end
      end
   endtask

   // Builds one NAL unit: prefix bytes, SPS syntax with random content, emulation
   // prevention, and now and then a cut or a trailing escape byte.
   task automatic build_unit(int kind, int prefix_len);
      logic [7:0] profile, b;
      longint unsigned chroma, poc;
      int zeros, cut, cycles_n;
      bit high, frame_mbs;
      bitstream.delete();
      nal_bytes.delete();
      for (int i = 0; i < prefix_len; i++)
         nal_bytes.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
      if (kind == UNIT_NOISE) begin
         repeat ($urandom_range(1, 12)) nal_bytes.push_back(8'($urandom));
         return;
      end
      case ($urandom_range(0, 3))
         0: profile = 66;
         1: profile = 8'($urandom);
         default: begin
            case ($urandom_range(0, 6))
               0: profile = 100; 1: profile = 110; 2: profile = 122; 3: profile = 244;
               4: profile = 44;  5: profile = 83;  default: profile = 86;
            endcase
         end
      endcase
      if (kind == UNIT_EXTREME) profile = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      put_bits(profile, 8);
      put_bits($urandom, 8);
      put_bits(kind == UNIT_EXTREME ? 8'hFF : 8'($urandom), 8);
      if (kind == UNIT_BAD_ID) put_ue($urandom_range(0, 1) ? 32 : pick_ue(100000) | 32);
      else put_ue($urandom_range(0, 9) == 0 ? 31 : $urandom_range(0, 31));
      high = profile inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86};
      if (high) begin
         chroma = $urandom_range(0, 9) == 0 ? pick_ue(10) : $urandom_range(0, 3);
         put_ue(chroma);
         if (chroma == 3) put_bits($urandom, 1);
         put_ue($urandom_range(0, 6));
         put_ue($urandom_range(0, 6));
         put_bits($urandom, 1);
         if ($urandom_range(0, 2) == 0) begin
            put_bits(1, 1);
            put_scaling_lists(chroma == 3 ? 12 : 8);
         end else put_bits(0, 1);
      end
      if (kind == UNIT_LONG) begin
         // 33 zeros: the 33rd still ends the prefix, then 32 arbitrary info bits.
         put_bits(0, 33);
         put_bits($urandom, 32);
      end else put_ue(pick_ue(16));
      poc = $urandom_range(0, 9) == 0 ? pick_ue(300) : $urandom_range(0, 2);
      if (kind == UNIT_LONG) poc = 64'hFFFF_FFFF;
      put_ue(poc);
      if (poc == 0) put_ue(pick_ue(16));
      else if (poc == 1) begin
         put_bits($urandom, 1);
         put_ue(pick_ue(50));
         put_ue(pick_ue(50));
         cycles_n = $urandom_range(0, 19) == 0 ? 300 : $urandom_range(0, 4);
         put_ue(cycles_n);
         repeat (cycles_n > 256 ? 256 : cycles_n) put_ue($urandom_range(0, 3));
      end
      put_ue($urandom_range(0, 16));
      put_bits($urandom, 1);
      if (kind == UNIT_EXTREME) begin
         put_ue(4095); put_ue(64'hFFFF_FFFF);
      end else begin
         put_ue($urandom_range(0, 9) == 0 ? pick_ue(8000) : $urandom_range(0, 120));
         put_ue($urandom_range(0, 9) == 0 ? pick_ue(8000) : $urandom_range(0, 70));
      end
      frame_mbs = $urandom;
      put_bits(frame_mbs, 1);
      if (!frame_mbs) put_bits($urandom, 1);
      put_bits($urandom, 1);
      if ($urandom_range(0, 1)) begin
         put_bits(1, 1);
         repeat (4) put_ue($urandom_range(0, 5) == 0 ? pick_ue(3000) : $urandom_range(0, 8));
      end else put_bits(0, 1);
      if ($urandom_range(0, 4) != 0) begin
         put_bits(1, 1);
         if ($urandom_range(0, 4) != 0) begin
            int idc;
            put_bits(1, 1);
            case ($urandom_range(0, 3))
               0: idc = 255;
               1: idc = $urandom_range(17, 254);
               default: idc = $urandom_range(0, 16);
            endcase
            put_bits(idc, 8);
            if (idc == 255) begin
               put_bits($urandom_range(0, 3) == 0 ? 0 : $urandom, 16);
               put_bits($urandom_range(0, 3) == 0 ? 0 : $urandom, 16);
            end
         end else put_bits(0, 1);
      end else put_bits(0, 1);
      // Rest of the VUI is ignored by the parser, so random filler is fine.
      repeat ($urandom_range(0, 20)) bitstream.push_back($urandom);
      bitstream.push_back(1);
      while (bitstream.size() % 8 != 0) bitstream.push_back(0);

      zeros = 0;
      for (int i = 0; i < bitstream.size(); i += 8) begin
         for (int k = 0; k < 8; k++) b[7 - k] = bitstream[i + k];
         if (zeros >= 2 && b <= 8'h03) begin
            nal_bytes.push_back(8'h03);
            zeros = 0;
         end
         nal_bytes.push_back(b);
         zeros = (b == 0) ? (zeros < 2 ? zeros + 1 : 2) : 0;
      end
      case ($urandom_range(0, 9))
         0: begin
            cut = $urandom_range(1, nal_bytes.size());
            while (nal_bytes.size() > cut) void'(nal_bytes.pop_back());
         end
         1: begin
            // An escape-like byte as the very last byte is kept and parsed.
            nal_bytes.push_back(8'h00); nal_bytes.push_back(8'h00);
            nal_bytes.push_back(8'h03);
         end
         default: ;
      endcase
   endtask

   task automatic send_item(logic [7:0] b, bit last);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.data_byte = b;
      req_ch.last_byte = last;
      do @(negedge clock); while (!req_taken);
   endtask

   task automatic send_unit();
      for (int i = 0; i < nal_bytes.size(); i++)
         send_item(nal_bytes[i], i == nal_bytes.size() - 1);
      req_ch.valid = 1'b0;
   endtask

   // Configuration is written only with nothing in flight: the task waits for the
   // last expected result, then pauses before the write.
   task automatic write_prefix_skip(logic [3:0] v);
      while (sps_model.expected_units.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.prefix_skip_bytes = v;
      do @(negedge clock); while (!csr_taken);
      csr_ch.valid = 1'b0;
   endtask

   task automatic run_random(int item_budget, int prefix_len);
      int start;
      int k;
      start = sps_model.bytes_taken;
      while (sps_model.bytes_taken - start < item_budget) begin
         k = $urandom_range(0, 19);
         build_unit(k == 0 ? UNIT_NOISE : k == 1 ? UNIT_BAD_ID :
                    k == 2 ? UNIT_LONG : k == 3 ? UNIT_EXTREME : UNIT_RANDOM,
                    prefix_len);
         send_unit();
      end
   endtask

   initial begin
      reset = 1'b1;
      idling_on = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.last_byte = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.prefix_skip_bytes = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed units under the reset prefix length: a unit cut inside the prefix,
      // an out-of-range id, long codes, and the extremes of the profile and size fields.
      nal_bytes.delete();
      nal_bytes.push_back(8'h00);
      send_unit();
      build_unit(UNIT_BAD_ID, 5);
      send_unit();
      build_unit(UNIT_LONG, 5);
      send_unit();
      build_unit(UNIT_EXTREME, 5);
      send_unit();

      // Random traffic across several prefix lengths, the extremes among them.
      run_random(300, 5);
      write_prefix_skip(4'd0);
      run_random(300, 0);
      write_prefix_skip(4'd15);
      run_random(250, 15);
      write_prefix_skip(4'd4);
      run_random(300, 4);
      begin
         logic [3:0] p;
         p = $urandom_range(1, 14);
         write_prefix_skip(p);
         // Closing phase runs with no idling on either side.
         idling_on = 1'b0;
         run_random(350, p);
      end

      while (sps_model.expected_units.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);

      $display("Checked %0d parsed units from %0d input items", sps_model.units_checked,
               sps_model.bytes_taken);
      $display("Status mix: ok %0d, bad id %0d, truncated %0d, out of range %0d",
               sps_model.status_seen[0], sps_model.status_seen[1],
               sps_model.status_seen[2], sps_model.status_seen[3]);
      if (sps_model.errors == 0)
         $display("[h264_sps_dimension_parser_core] OK");
      else
         $display("[h264_sps_dimension_parser_core] ERROR");
      $finish;
   end

endmodule
